// File: hdl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and byte functions for the AES-128 encrypt pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  typedef logic [127:0] state_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_KEY_UPPER = 1'b0,
    REG_KEY_LOWER = 1'b1
  } reg_idx_e;

  // Forward S-box
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constants, indexed by round minus one
  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Byte i of the state sits at bits 127-8i downto 120-8i
  function automatic logic [7:0] get_byte(state_t s, int unsigned i);
    return s[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round key from the current one
  function automatic state_t key_step(state_t rk, logic [7:0] rc);
    state_t     nk;
    logic [7:0] t [4];
    t[0] = SBOX[get_byte(rk, 13)] ^ rc;
    t[1] = SBOX[get_byte(rk, 14)];
    t[2] = SBOX[get_byte(rk, 15)];
    t[3] = SBOX[get_byte(rk, 12)];
    for (int i = 0; i < 4; i++) begin
      nk[127 - 8*i -: 8] = get_byte(rk, i) ^ t[i];
    end
    for (int i = 4; i < 16; i++) begin
      nk[127 - 8*i -: 8] = get_byte(rk, i) ^ nk[127 - 8*(i-4) -: 8];
    end
    return nk;
  endfunction

  // SubBytes, ShiftRows, optional MixColumns, AddRoundKey
  function automatic state_t round_fn(state_t s, state_t rk, logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    state_t     o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4 + r] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4];
      a1 = t[c*4 + 1];
      a2 = t[c*4 + 2];
      a3 = t[c*4 + 3];
      if (last) begin
        o[127 - 8*(c*4)     -: 8] = a0;
        o[127 - 8*(c*4 + 1) -: 8] = a1;
        o[127 - 8*(c*4 + 2) -: 8] = a2;
        o[127 - 8*(c*4 + 3) -: 8] = a3;
      end else begin
        o[127 - 8*(c*4)     -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        o[127 - 8*(c*4 + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        o[127 - 8*(c*4 + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        o[127 - 8*(c*4 + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    return o ^ rk;
  endfunction

endpackage

// File: hdl/aes_round.sv
// ----------------------------------------------------------------------------
// aes_round
// One pipeline stage: a full cipher round plus, except in the last round, the key step for the next one.
// ----------------------------------------------------------------------------
module aes_round #(
  parameter int unsigned Round = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  aes_pkg::state_t state_i,
  input  aes_pkg::state_t key_i,
  output logic            valid_o,
  output aes_pkg::state_t state_o,
  output aes_pkg::state_t key_o
);
  import aes_pkg::*;

  state_t key_d, state_d;
  logic   valid_q;
  state_t key_q, state_q;

  // key_i is already this round's key; the next key is derived in parallel
  assign state_d = round_fn(state_i, key_i, Round == NumRounds);

  if (Round < NumRounds) begin : g_key
    assign key_d = key_step(key_i, RCON[Round]);
  end else begin : g_no_key
    assign key_d = key_i;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      key_q   <= key_d;
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

// File: hdl/aes128_block_encrypt_top.sv
// Pipeline: 1 AddRoundKey stage plus 10 round stages between input acceptance and
// result valid, one register stage per AES round.
// Throughput: one block per cycle; the whole pipeline advances unless the
// output is valid and stalled, with each bubble stage filled independently.
// Reset: all stage valid bits clear asynchronously; key registers reset to 0.
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top
// AES-128 encryption pipeline with the cipher key in two config registers.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  // plaintext in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] block_upper_i,
  input  logic [63:0] block_lower_i,
  // ciphertext out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] cipher_upper_o,
  output logic [63:0] cipher_lower_o
);
  import aes_pkg::*;

  localparam int unsigned NumStages = NumRounds + 1;

  logic [63:0] key_upper_q, key_lower_q;
  logic        valid_s [NumStages];
  state_t      state_s [NumStages];
  state_t      key_s   [NumStages];
  logic        en      [NumStages];
  logic        v0_q;
  state_t      s0_q, k0_q;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= '0;
      key_lower_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_KEY_UPPER: key_upper_q <= cfg_data_i;
        REG_KEY_LOWER: key_lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves if it is empty or the one after it moves
  always_comb begin
    en[NumStages-1] = !valid_s[NumStages-1] || !out_stall_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !valid_s[i] || en[i+1];
    end
  end

  assign in_stall_o = !en[0];

  // Stage 0: initial AddRoundKey and the first round key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en[0]) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      s0_q <= {block_upper_i, block_lower_i} ^ {key_upper_q, key_lower_q};
      k0_q <= key_step({key_upper_q, key_lower_q}, RCON[0]);
    end
  end

  assign valid_s[0] = v0_q;
  assign state_s[0] = s0_q;
  assign key_s[0]   = k0_q;

  // Round stages
  for (genvar g = 1; g < NumStages; g++) begin : g_round
    aes_round #(.Round(g)) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[g]),
      .valid_i (valid_s[g-1]),
      .state_i (state_s[g-1]),
      .key_i   (key_s[g-1]),
      .valid_o (valid_s[g]),
      .state_o (state_s[g]),
      .key_o   (key_s[g])
    );
  end

  assign out_valid_o    = valid_s[NumStages-1];
  assign cipher_upper_o = state_s[NumStages-1][127:64];
  assign cipher_lower_o = state_s[NumStages-1][63:0];

endmodule

// File: hdl/aes_checker.sv
// ----------------------------------------------------------------------------
// aes_checker
// Port-level checks for the AES-128 encryption pipeline.
// ----------------------------------------------------------------------------
module aes_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] cipher_upper_o,
  input logic [63:0] cipher_lower_o
);

  // A stalled result holds its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(cipher_upper_o) && $stable(cipher_lower_o))
    else $error("stalled result changed");

  // Input only stalls when the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // No result appears without an earlier accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 11) || $past(out_valid_o))
    else $error("result without transaction");

endmodule

bind aes128_block_encrypt_top aes_checker u_aes_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .cipher_upper_o (cipher_upper_o),
  .cipher_lower_o (cipher_lower_o)
);

// File: test/tb_aes128_block_encrypt_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes128_block_encrypt_top
// Drives plaintext blocks into the AES-128 encrypt pipeline under several
// keys and compares each ciphertext against a behavioral cipher, in order.
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt_top;
  import aes_pkg::*;

  // Ciphertexts still owed by the pipeline, oldest first
  class cipher_board;
    logic [127:0] owed [$];
    int           errors = 0;
    int           checked = 0;

    function void note_block(logic [127:0] ct);
      owed.push_back(ct);
    endfunction

    function void check_result(logic [63:0] up, logic [63:0] lo);
      logic [127:0] ct;
      if (owed.size() == 0) begin
        $display("%0t: unexpected ciphertext %h_%h", $realtime, up, lo);
        errors++;
        return;
      end
      ct = owed.pop_front();
      checked++;
      if (ct[127:64] !== up) begin
        $display("%0t: cipher_upper expected %h actual %h", $realtime, ct[127:64], up);
        errors++;
      end
      if (ct[63:0] !== lo) begin
        $display("%0t: cipher_lower expected %h actual %h", $realtime, ct[63:0], lo);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = REG_KEY_UPPER;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] block_upper_i = '0;
  logic [63:0] block_lower_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] cipher_upper_o;
  logic [63:0] cipher_lower_o;

  cipher_board  board = new();
  logic [127:0] cur_key = '0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           hold_left = 0;
  int           cycles = 0;
  int           blocks_sent = 0;

  localparam int CycleLimit = 400000;

  aes128_block_encrypt_top dut (.*);

  always #2 clk_i = ~clk_i;

  // ---------------- behavioral cipher ----------------
  function automatic logic [7:0] gdouble(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) acc ^= a;
      a = gdouble(a);
      b = b >> 1;
    end
    return acc;
  endfunction

  // S-box value: inverse as x^254, then the affine map
  function automatic logic [7:0] subst(logic [7:0] x);
    logic [7:0] p, inv;
    p = x;
    inv = 8'h01;
    for (int i = 1; i < 8; i++) begin
      p = gmul(p, p);
      inv = gmul(inv, p);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
           ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [127:0] encrypt_block(logic [127:0] key, logic [127:0] pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] rk [16];
    logic [7:0] rc, k0, k1, k2, k3, a0, a1, a2, a3;
    logic [127:0] ct;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8*i -: 8];
      s[i] = pt[127 - 8*i -: 8] ^ rk[i];
    end
    for (int rnd = 1; rnd <= 10; rnd++) begin
      // key expansion step
      k0 = subst(rk[13]) ^ rc;
      k1 = subst(rk[14]);
      k2 = subst(rk[15]);
      k3 = subst(rk[12]);
      rk[0] ^= k0; rk[1] ^= k1; rk[2] ^= k2; rk[3] ^= k3;
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      rc = gdouble(rc);
      // SubBytes and ShiftRows, index = column*4 + row
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[c*4 + r] = subst(s[((c + r) % 4) * 4 + r]);
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        if (rnd < 10) begin
          s[c*4]   = gdouble(a0) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
          s[c*4+1] = a0 ^ gdouble(a1) ^ gmul(a2, 8'h03) ^ a3;
          s[c*4+2] = a0 ^ a1 ^ gdouble(a2) ^ gmul(a3, 8'h03);
          s[c*4+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gdouble(a3);
        end else begin
          s[c*4] = a0; s[c*4+1] = a1; s[c*4+2] = a2; s[c*4+3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[i];
    end
    for (int i = 0; i < 16; i++) ct[127 - 8*i -: 8] = s[i];
    return ct;
  endfunction

  // ---------------- timeout ----------------
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------- result side: check, then pick next stall ----------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(cipher_upper_o, cipher_lower_o);
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------- sender tasks ----------------
  task automatic send_block(logic [63:0] up, logic [63:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    block_upper_i <= up;
    block_lower_i <= lo;
    board.note_block(encrypt_block(cur_key, {up, lo}));
    blocks_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Waits until every owed ciphertext has been checked, then lets the pipeline idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_key(logic [127:0] key);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_KEY_UPPER;
    cfg_data_i <= key[127:64];
    @(posedge clk_i);
    cfg_idx_i <= REG_KEY_LOWER;
    cfg_data_i <= key[63:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_key = key;
  endtask

  task automatic random_blocks(int n);
    logic [63:0] up, lo;
    for (int i = 0; i < n; i++) begin
      up = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      case ($urandom_range(9))
        0: up = '0;
        1: lo = '1;
        2: begin up = '1; lo = '0; end
        default: ;
      endcase
      send_block(up, lo);
    end
  endtask

  // ---------------- main sequence ----------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key never written, then edge keys and the standard vector
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    write_key({64'h0001020304050607, 64'h08090a0b0c0d0e0f});
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    write_key('1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    write_key({64'hffffffffffffffff, 64'h0});
    send_block('0, '1);
    write_key({64'h0, 64'hffffffffffffffff});
    send_block('1, '0);

    // Random phases with varied idling and fresh keys
    write_key({$urandom, $urandom, $urandom, $urandom});
    send_idle_pct = 0;  stall_pct = 0;
    random_blocks(140);
    write_key({$urandom, $urandom, $urandom, $urandom});
    send_idle_pct = 69; stall_pct = 0;
    random_blocks(120);
    write_key({$urandom, $urandom, $urandom, $urandom});
    send_idle_pct = 0;  stall_pct = 69;
    random_blocks(120);
    write_key({$urandom, $urandom, $urandom, $urandom});
    send_idle_pct = 34; stall_pct = 34;
    random_blocks(120);

    // Long receiver hold-off while the sender keeps pushing
    drain();
    send_idle_pct = 0;  stall_pct = 0;
    hold_left = 300;
    random_blocks(60);
    drain();
    write_key('0);
    send_idle_pct = 34; stall_pct = 34;
    random_blocks(120);

    drain();
    repeat (20) @(posedge clk_i);
    $display("Encrypted %0d blocks under ten keys incl. all-zero and all-one,",
             blocks_sent);
    $display("with sender gaps, output stalls and a long backpressure hold-off.");
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/aes_pkg.sv
hdl/aes_round.sv
hdl/aes128_block_encrypt_top.sv
hdl/aes_checker.sv
test/tb_aes128_block_encrypt_top.sv
